// File: design/rc3t_pkg.sv
// Shared types, constants and helper functions for the RGB 3x3 convolution block.
// Used by every module of the block but rc3t_ram; depends on nothing else.
package rc3t_pkg;

	// Geometry and datapath sizing
	localparam int MAX_WIDTH    = 4096;
	localparam int KERNEL_SIZE  = 3;
	localparam int CHANNEL_BITS = 16;
	localparam int NUM_CH       = 3;
	localparam int PIX_W        = NUM_CH * CHANNEL_BITS;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int WID_W        = COL_W + 1;
	localparam int ROW_W        = 16;
	localparam int OCOL_W       = 12;
	localparam int COEF_W       = 8;
	localparam int KROW_W       = KERNEL_SIZE * COEF_W;
	localparam int PROD_W       = CHANNEL_BITS + 1 + COEF_W;
	localparam int RSUM_W       = PROD_W + 2;
	localparam int SUM_W        = 28;
	localparam int MAXV_W       = 27;
	localparam int THR_W        = 27;
	localparam int WREG_W       = 13;
	localparam int HREG_W       = 16;

	// Register port sizing
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// Register reset values
	localparam logic [WREG_W-1:0] WIDTH_RST  = 13'd640;
	localparam logic [HREG_W-1:0] HEIGHT_RST = 16'd480;

	// Register indexes, one 32-bit word each
	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_THRESH = 3'd2,
		REG_KTOP   = 3'd3,
		REG_KMID   = 3'd4,
		REG_KBOT   = 3'd5
	} reg_idx_t;

	// Request payloads on the pixel and result channels
	typedef struct packed {
		logic [15:0] red_in;
		logic [15:0] green_in;
		logic [15:0] blue_in;
	} pix_t;

	typedef struct packed {
		logic [ROW_W-1:0]        out_row;
		logic [OCOL_W-1:0]       out_col;
		logic signed [SUM_W-1:0] red_out;
		logic signed [SUM_W-1:0] green_out;
		logic signed [SUM_W-1:0] blue_out;
		logic [MAXV_W-1:0]       frame_max;
		logic                    last_of_frame;
	} res_t;

	// Kernel rows, top row at index 0, left coefficient in the low byte
	typedef logic [KERNEL_SIZE-1:0][KROW_W-1:0] krows_t;

	typedef struct packed {
		logic [WREG_W-1:0]       image_width;
		logic [HREG_W-1:0]       image_height;
		logic signed [THR_W-1:0] threshold;
		krows_t                  kernel_rows;
	} cfg_t;

	// Pixel as held in the line stores: red in the low lane
	typedef logic [CHANNEL_BITS-1:0] sample_t;
	typedef sample_t [NUM_CH-1:0] lpix_t;
	typedef lpix_t [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] win_t;
	typedef sample_t [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] lwin_t;

	// Position and frame-end flag that travel alongside a result
	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [OCOL_W-1:0] col;
		logic              last;
	} meta_t;

	// Window stage status handed to the lane pipeline
	typedef struct packed {
		logic  valid;
		logic  produce;
		meta_t meta;
	} win_stat_t;

	// Load enables of the three lane stages
	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} lane_en_t;

	// Per-lane result: thresholded sum and its positive part
	typedef struct packed {
		logic signed [SUM_W-1:0] value;
		logic [MAXV_W-1:0]       pos;
	} lane_res_t;

	typedef lane_res_t [NUM_CH-1:0] lane_res_arr_t;

	// Keep the low CHANNEL_BITS of each colour and pack them red first.
	function automatic lpix_t pix_pack(pix_t p);
		lpix_t v;
		v[0] = p.red_in[CHANNEL_BITS-1:0];
		v[1] = p.green_in[CHANNEL_BITS-1:0];
		v[2] = p.blue_in[CHANNEL_BITS-1:0];
		return v;
	endfunction

endpackage

// File: design/rc3t_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; no package is used.
module rc3t_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: design/rc3t_regs.sv
// APB-style configuration registers of the convolution block.
// Depends on rc3t_pkg for the register map and the configuration struct.
module rc3t_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rc3t_pkg::APB_AW-1:0]   paddr,
	input  logic [rc3t_pkg::APB_DW-1:0]   pwdata,
	output logic [rc3t_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output rc3t_pkg::cfg_t                cfg
);
	import rc3t_pkg::*;

	cfg_t     cfg_q;
	logic     wr_req;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_req = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
	assign cfg    = cfg_q;

	// Register writes in the access phase; unknown addresses are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= WIDTH_RST;
			cfg_q.image_height <= HEIGHT_RST;
			cfg_q.threshold    <= '0;
			cfg_q.kernel_rows  <= '0;
		end else if (wr_req) begin
			case (idx)
				REG_WIDTH:  cfg_q.image_width    <= pwdata[WREG_W-1:0];
				REG_HEIGHT: cfg_q.image_height   <= pwdata[HREG_W-1:0];
				REG_THRESH: cfg_q.threshold      <= pwdata[THR_W-1:0];
				REG_KTOP:   cfg_q.kernel_rows[0] <= pwdata[KROW_W-1:0];
				REG_KMID:   cfg_q.kernel_rows[1] <= pwdata[KROW_W-1:0];
				REG_KBOT:   cfg_q.kernel_rows[2] <= pwdata[KROW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read-back of the stored values.
	always_comb begin
		case (idx)
			REG_WIDTH:  prdata = APB_DW'(cfg_q.image_width);
			REG_HEIGHT: prdata = APB_DW'(cfg_q.image_height);
			REG_THRESH: prdata = APB_DW'(cfg_q.threshold[THR_W-1:0]);
			REG_KTOP:   prdata = APB_DW'(cfg_q.kernel_rows[0]);
			REG_KMID:   prdata = APB_DW'(cfg_q.kernel_rows[1]);
			REG_KBOT:   prdata = APB_DW'(cfg_q.kernel_rows[2]);
			default:    prdata = '0;
		endcase
	end

endmodule

// File: design/rc3t_window.sv
// Raster counters, two line stores and the 3x3 pixel window.
// Depends on rc3t_pkg and instantiates rc3t_ram for each line store.
module rc3t_window (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rc3t_pkg::cfg_t        cfg,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  rc3t_pkg::pix_t        pix,
	input  logic                  take_s3,
	output rc3t_pkg::win_t        win,
	output rc3t_pkg::win_stat_t   stat
);
	import rc3t_pkg::*;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [WID_W-1:0] w_eff;
	logic [ROW_W-1:0] h_eff;
	logic             col_last;
	logic             row_last;
	logic             accept;
	logic             take_s1;
	logic             take_s2;
	logic             move_s1;

	logic             valid_s1;
	lpix_t            px_s1;
	logic [COL_W-1:0] col_s1;
	logic             produce_s1;
	meta_t            meta_s1;

	logic             valid_s2;
	logic             produce_s2;
	meta_t            meta_s2;
	win_t             win_s2;

	lpix_t            up_rd;
	lpix_t            lo_rd;

	// Effective frame size: both sides at least the kernel, width at most the store.
	always_comb begin
		if (int'(cfg.image_width) < KERNEL_SIZE) begin
			w_eff = WID_W'(KERNEL_SIZE);
		end else if (int'(cfg.image_width) > MAX_WIDTH) begin
			w_eff = WID_W'(MAX_WIDTH);
		end else begin
			w_eff = WID_W'(cfg.image_width);
		end
		if (int'(cfg.image_height) < KERNEL_SIZE) begin
			h_eff = ROW_W'(KERNEL_SIZE);
		end else begin
			h_eff = cfg.image_height;
		end
	end

	assign col_last = ({1'b0, col_q} + WID_W'(1)) >= w_eff;
	assign row_last = ({1'b0, row_q} + (ROW_W + 1)'(1)) >= {1'b0, h_eff};

	// Stage handshake: a stage loads when it is empty or its item moves on.
	assign take_s2   = !valid_s2 || take_s3;
	assign take_s1   = !valid_s1 || take_s2;
	assign pix_ready = take_s1;
	assign accept    = pix_valid && pix_ready;
	assign move_s1   = valid_s1 && take_s2;

	// Raster position of the next pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				if (row_last) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Line stores: read at acceptance, written back one stage later.
	rc3t_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_upper (
		.clk     (clk),
		.wr_en   (move_s1),
		.wr_addr (col_s1),
		.wr_data (lo_rd),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (up_rd)
	);

	rc3t_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_lower (
		.clk     (clk),
		.wr_en   (move_s1),
		.wr_addr (col_s1),
		.wr_data (px_s1),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (lo_rd)
	);

	// Stage 1: the accepted pixel waits for its line store data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_s1) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1        <= pix_pack(pix);
			col_s1       <= col_q;
			produce_s1   <= (int'(row_q) >= KERNEL_SIZE - 1) && (int'(col_q) >= KERNEL_SIZE - 1);
			meta_s1.row  <= row_q - ROW_W'(1);
			meta_s1.col  <= OCOL_W'(col_q - COL_W'(1));
			meta_s1.last <= row_last && col_last;
		end
	end

	// Stage 2: the window shifts one column for every pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			for (int a = 0; a < KERNEL_SIZE; a++) begin
				for (int b = 0; b < KERNEL_SIZE - 1; b++) begin
					win_s2[a][b] <= win_s2[a][b+1];
				end
			end
			win_s2[0][KERNEL_SIZE-1] <= up_rd;
			win_s2[1][KERNEL_SIZE-1] <= lo_rd;
			win_s2[2][KERNEL_SIZE-1] <= px_s1;
			produce_s2 <= produce_s1;
			meta_s2    <= meta_s1;
		end
	end

	assign win = win_s2;

	always_comb begin
		stat.valid   = valid_s2;
		stat.produce = produce_s2;
		stat.meta    = meta_s2;
	end

	// The write-back and the next read never hit the same line store entry.
	a_no_addr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(move_s1 && accept) |-> (col_s1 != col_q))
		else $error("line store read and write collide");

	// Input back-pressure only arises when both front stages are occupied.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> (valid_s1 && valid_s2))
		else $error("input stalled with a bubble in the front stages");

endmodule

// File: design/rc3t_lane.sv
// One colour lane: nine products, row sums, total and threshold.
// Depends on rc3t_pkg for widths and the lane result struct.
module rc3t_lane (
	input  logic                            clk,
	input  rc3t_pkg::lane_en_t              en,
	input  rc3t_pkg::lwin_t                 win,
	input  rc3t_pkg::krows_t                kernel,
	input  logic signed [rc3t_pkg::THR_W-1:0] threshold,
	output rc3t_pkg::lane_res_t             res
);
	import rc3t_pkg::*;

	logic signed [PROD_W-1:0] prod_s3 [KERNEL_SIZE][KERNEL_SIZE];
	logic signed [RSUM_W-1:0] rsum_d  [KERNEL_SIZE];
	logic signed [RSUM_W-1:0] rsum_s4 [KERNEL_SIZE];
	logic signed [SUM_W-1:0]  total;
	logic signed [SUM_W-1:0]  thr_ext;
	logic signed [SUM_W-1:0]  value;
	logic [MAXV_W-1:0]        pos;
	lane_res_t                res_s5;

	// Stage 3: unsigned sample times signed coefficient, one multiplier per tap.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int a = 0; a < KERNEL_SIZE; a++) begin
				for (int b = 0; b < KERNEL_SIZE; b++) begin
					prod_s3[a][b] <= $signed({1'b0, win[a][b]}) *
						$signed(kernel[a][COEF_W*b +: COEF_W]);
				end
			end
		end
	end

	// Stage 4: sum of each kernel row.
	always_comb begin
		for (int a = 0; a < KERNEL_SIZE; a++) begin
			rsum_d[a] = '0;
			for (int b = 0; b < KERNEL_SIZE; b++) begin
				rsum_d[a] = rsum_d[a] + RSUM_W'(prod_s3[a][b]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			for (int a = 0; a < KERNEL_SIZE; a++) begin
				rsum_s4[a] <= rsum_d[a];
			end
		end
	end

	// Stage 5: full sum, then sums below the threshold are forced to zero.
	always_comb begin
		total = '0;
		for (int a = 0; a < KERNEL_SIZE; a++) begin
			total = total + SUM_W'(rsum_s4[a]);
		end
		thr_ext = SUM_W'(threshold);
		if (total < thr_ext) begin
			value = '0;
		end else begin
			value = total;
		end
		if (!value[SUM_W-1] && (value != '0)) begin
			pos = value[MAXV_W-1:0];
		end else begin
			pos = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			res_s5.value <= value;
			res_s5.pos   <= pos;
		end
	end

	assign res = res_s5;

endmodule

// File: design/rc3t_merge.sv
// Merging stage: frame maximum over the three lanes and the result register.
// Depends on rc3t_pkg for the lane and result structs.
module rc3t_merge (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	input  rc3t_pkg::meta_t         item_meta,
	input  rc3t_pkg::lane_res_arr_t lane_res,
	output logic                    take_s6,
	output logic                    res_valid,
	input  logic                    res_ready,
	output rc3t_pkg::res_t          res
);
	import rc3t_pkg::*;

	logic [MAXV_W-1:0] run_max_q;
	logic [MAXV_W-1:0] max_a;
	logic [MAXV_W-1:0] max_b;
	logic [MAXV_W-1:0] frame_max_d;
	logic              valid_s6;
	res_t              res_s6;

	function automatic logic [MAXV_W-1:0] max2(logic [MAXV_W-1:0] x, logic [MAXV_W-1:0] y);
		return (x > y) ? x : y;
	endfunction

	// Two-level compare of the lanes against the running maximum.
	assign max_a       = max2(lane_res[0].pos, lane_res[1].pos);
	assign max_b       = max2(lane_res[2].pos, run_max_q);
	assign frame_max_d = max2(max_a, max_b);

	assign take_s6 = !valid_s6 || res_ready;

	// Running maximum; cleared once the last result of a frame has been formed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_max_q <= '0;
			valid_s6  <= 1'b0;
		end else if (take_s6) begin
			valid_s6 <= item_valid;
			if (item_valid) begin
				if (item_meta.last) begin
					run_max_q <= '0;
				end else begin
					run_max_q <= frame_max_d;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (take_s6) begin
			res_s6.out_row       <= item_meta.row;
			res_s6.out_col       <= item_meta.col;
			res_s6.red_out       <= lane_res[0].value;
			res_s6.green_out     <= lane_res[1].value;
			res_s6.blue_out      <= lane_res[2].value;
			res_s6.frame_max     <= frame_max_d;
			res_s6.last_of_frame <= item_meta.last;
		end
	end

	assign res_valid = valid_s6;
	assign res       = res_s6;

	// A reported maximum covers every positive channel of the same result.
	a_max_covers: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 |->
			(res_s6.red_out[SUM_W-1] || (res_s6.red_out[SUM_W-2:0] <= res_s6.frame_max)) &&
			(res_s6.green_out[SUM_W-1] ||
				(res_s6.green_out[SUM_W-2:0] <= res_s6.frame_max)) &&
			(res_s6.blue_out[SUM_W-1] || (res_s6.blue_out[SUM_W-2:0] <= res_s6.frame_max)))
		else $error("frame maximum below a channel result");

	// Within a frame the maximum never falls from one result to the next.
	a_max_rising: assert property (@(posedge clk) disable iff (!arst_n)
		(take_s6 && item_valid && valid_s6 && !res_s6.last_of_frame) |=>
			(res_s6.frame_max >= $past(res_s6.frame_max)))
		else $error("frame maximum decreased within a frame");

endmodule

// File: design/rgb_conv3x3_threshold.sv
// Streaming 3x3 convolution on RGB pixels with a threshold and a running frame maximum.
// Throughput: one pixel per clock unless res_ready stalls the output, set by one read and one
// write of the line stores per pixel. Results pass the stages s1 to s5 and the output register s6.
// Reset clears counters, stage valids, running maximum and registers to their defaults;
// line stores are not cleared and no clearing pass is needed. Uses rc3t_pkg and all rc3t_ modules.
module rgb_conv3x3_threshold (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rc3t_pkg::APB_AW-1:0] paddr,
	input  logic [rc3t_pkg::APB_DW-1:0] pwdata,
	output logic [rc3t_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	input  logic                        pix_valid,
	output logic                        pix_ready,
	input  rc3t_pkg::pix_t              pix,
	output logic                        res_valid,
	input  logic                        res_ready,
	output rc3t_pkg::res_t              res
);
	import rc3t_pkg::*;

	cfg_t          cfg;
	win_t          win_s2;
	win_stat_t     stat_s2;
	lane_en_t      lane_en;
	lane_res_arr_t lane_res;

	logic  take_s3;
	logic  take_s4;
	logic  take_s5;
	logic  take_s6;
	logic  valid_s3;
	logic  valid_s4;
	logic  valid_s5;
	meta_t meta_s3;
	meta_t meta_s4;
	meta_t meta_s5;

	// Configuration registers.
	rc3t_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Line stores and window.
	rc3t_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.take_s3   (take_s3),
		.win       (win_s2),
		.stat      (stat_s2)
	);

	// Stage handshake of the lane pipeline; border pixels drop out at stage 3.
	assign take_s5 = !valid_s5 || take_s6;
	assign take_s4 = !valid_s4 || take_s5;
	assign take_s3 = !valid_s3 || take_s4;

	always_comb begin
		lane_en.s3 = take_s3;
		lane_en.s4 = take_s4;
		lane_en.s5 = take_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (take_s3) begin
				valid_s3 <= stat_s2.valid && stat_s2.produce;
			end
			if (take_s4) begin
				valid_s4 <= valid_s3;
			end
			if (take_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// Position and frame-end flag follow the lanes.
	always_ff @(posedge clk) begin
		if (take_s3) begin
			meta_s3 <= stat_s2.meta;
		end
		if (take_s4) begin
			meta_s4 <= meta_s3;
		end
		if (take_s5) begin
			meta_s5 <= meta_s4;
		end
	end

	// One lane per colour channel.
	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
		lwin_t lane_win;

		always_comb begin
			for (int a = 0; a < KERNEL_SIZE; a++) begin
				for (int b = 0; b < KERNEL_SIZE; b++) begin
					lane_win[a][b] = win_s2[a][b][ch];
				end
			end
		end

		rc3t_lane u_lane (
			.clk       (clk),
			.en        (lane_en),
			.win       (lane_win),
			.kernel    (cfg.kernel_rows),
			.threshold (cfg.threshold),
			.res       (lane_res[ch])
		);
	end

	// Merge of the lanes and result register.
	rc3t_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s5),
		.item_meta  (meta_s5),
		.lane_res   (lane_res),
		.take_s6    (take_s6),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

endmodule
